// File: hdl/assert_macros.svh
// assertion macros shared by the generator top and its config register file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define MRG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition must never be seen at a clock edge out of reset
`define MRG_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define MRG_ASSERT(label, prop, msg)
`define MRG_ASSERT_NEVER(label, cond, msg)
`endif

`endif

// File: hdl/mrg3_pkg.sv
// types and constants of the third-order recursive generator
`timescale 1ns / 1ps

package mrg3_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned MultWidth = 16;
  localparam int unsigned CfgIdxWidthDef = 8;

  // modulus 2^32 - 5, and 2^32 mod modulus used for folding
  localparam logic [WordWidth-1:0] Modulus = 32'hFFFF_FFFB;
  localparam logic [2:0] FoldFactor = 3'd5;

  localparam logic [WordWidth-1:0] SeedReset = 32'd10;
  localparam logic [MultWidth-1:0] MultNewestReset = 16'd1176;
  localparam logic [MultWidth-1:0] MultMiddleReset = 16'd1476;
  localparam logic [MultWidth-1:0] MultOldestReset = 16'd1776;

  typedef enum logic [1:0] {
    CFG_SEED        = 2'd0,
    CFG_MULT_NEWEST = 2'd1,
    CFG_MULT_MIDDLE = 2'd2,
    CFG_MULT_OLDEST = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [WordWidth-1:0] seed_value;
    logic [MultWidth-1:0] mult_newest;
    logic [MultWidth-1:0] mult_middle;
    logic [MultWidth-1:0] mult_oldest;
  } cfg_regs_t;

endpackage

// File: hdl/third_order_recursive_random_generator.sv
// Third-order multiple recursive generator, residues modulo 2^32 - 5.
// Input channel (in_valid_i / in_ready_o, payload restart_i): each transfer
// is one request. restart_i set loads all three history words from the seed
// register before the step. Output channel (out_valid_o / out_ready_i,
// payload random_word_o): exactly one word per request, in request order.
// Configuration channel (cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i):
// index 0 seed, 1..3 multipliers of newest, middle and oldest word; other
// indexes dropped. Always ready; only the user keeps it written while idle.
// Latency: the word appears in the cycle after the request transfer.
// Throughput: one request per cycle while the receiver keeps up; the history
// feedback via three 16x32 multiplies and the modular fold is combinational.
// A stalled receiver holds the output register; a new request is taken in
// the same cycle the pending word is transferred out.
// Reset: history words and seed are 10, multipliers 1176, 1476 and 1776,
// output empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module third_order_recursive_random_generator #(
  parameter int unsigned CfgIdxWidth = mrg3_pkg::CfgIdxWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           restart_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mrg3_pkg::WordWidth-1:0] random_word_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]         cfg_index_i,
  input  logic [mrg3_pkg::WordWidth-1:0] cfg_data_i
);

  mrg3_pkg::cfg_regs_t cfg;

  logic [mrg3_pkg::WordWidth-1:0] hist_newest_q, hist_middle_q, hist_oldest_q;
  logic [mrg3_pkg::WordWidth-1:0] op_newest, op_middle;
  logic [mrg3_pkg::WordWidth-1:0] word_d, word_q;
  logic                           out_valid_q;
  logic                           in_xfer;

  mrg3_cfg #(
    .CfgIdxWidth (CfgIdxWidth)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mrg3_step u_step (
    .restart_i     (restart_i),
    .hist_newest_i (hist_newest_q),
    .hist_middle_i (hist_middle_q),
    .hist_oldest_i (hist_oldest_q),
    .cfg_i         (cfg),
    .op_newest_o   (op_newest),
    .op_middle_o   (op_middle),
    .word_o        (word_d)
  );

  // output register frees up when its word is transferred out
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_newest_q <= mrg3_pkg::SeedReset;
      hist_middle_q <= mrg3_pkg::SeedReset;
      hist_oldest_q <= mrg3_pkg::SeedReset;
      out_valid_q   <= 1'b0;
    end else if (in_xfer) begin
      hist_newest_q <= word_d;
      hist_middle_q <= op_newest;
      hist_oldest_q <= op_middle;
      out_valid_q   <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q   <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign random_word_o = word_q;

  `MRG_ASSERT(word_in_range_a,
    out_valid_o |-> (random_word_o < mrg3_pkg::Modulus),
    "output word is not a residue")
  `MRG_ASSERT(request_gives_word_a,
    in_xfer |=> (out_valid_o && random_word_o == hist_newest_q),
    "request did not load output and newest history together")
  `MRG_ASSERT(history_shift_a,
    in_xfer |=> (hist_oldest_q == $past(op_middle)),
    "history did not shift down")
  `MRG_ASSERT_NEVER(ready_while_stalled_a,
    in_ready_o && out_valid_o && !out_ready_i,
    "request taken while pending word is stalled")

endmodule

// File: hdl/mrg3_cfg.sv
// configuration register file: seed and the three multipliers
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mrg3_cfg #(
  parameter int unsigned CfgIdxWidth = mrg3_pkg::CfgIdxWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]              cfg_index_i,
  input  logic [mrg3_pkg::WordWidth-1:0]      cfg_data_i,
  output mrg3_pkg::cfg_regs_t                 cfg_o
);

  mrg3_pkg::cfg_regs_t cfg_q, cfg_d;

  // writes are always taken
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgIdxWidth'(mrg3_pkg::CFG_SEED): begin
          cfg_d.seed_value = cfg_data_i;
        end
        CfgIdxWidth'(mrg3_pkg::CFG_MULT_NEWEST): begin
          cfg_d.mult_newest = cfg_data_i[mrg3_pkg::MultWidth-1:0];
        end
        CfgIdxWidth'(mrg3_pkg::CFG_MULT_MIDDLE): begin
          cfg_d.mult_middle = cfg_data_i[mrg3_pkg::MultWidth-1:0];
        end
        CfgIdxWidth'(mrg3_pkg::CFG_MULT_OLDEST): begin
          cfg_d.mult_oldest = cfg_data_i[mrg3_pkg::MultWidth-1:0];
        end
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seed_value  <= mrg3_pkg::SeedReset;
      cfg_q.mult_newest <= mrg3_pkg::MultNewestReset;
      cfg_q.mult_middle <= mrg3_pkg::MultMiddleReset;
      cfg_q.mult_oldest <= mrg3_pkg::MultOldestReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

  `MRG_ASSERT(cfg_mult_newest_write_a,
    (cfg_valid_i && cfg_index_i == CfgIdxWidth'(mrg3_pkg::CFG_MULT_NEWEST)) |=>
    (cfg_q.mult_newest == $past(cfg_data_i[mrg3_pkg::MultWidth-1:0])),
    "mult_newest did not take the written value")

endmodule

// File: hdl/mrg3_step.sv
// one generator step: restart select, weighted sum and reduction mod 2^32-5
`timescale 1ns / 1ps

module mrg3_step (
  input  logic                           restart_i,
  input  logic [mrg3_pkg::WordWidth-1:0] hist_newest_i,
  input  logic [mrg3_pkg::WordWidth-1:0] hist_middle_i,
  input  logic [mrg3_pkg::WordWidth-1:0] hist_oldest_i,
  input  mrg3_pkg::cfg_regs_t            cfg_i,
  output logic [mrg3_pkg::WordWidth-1:0] op_newest_o,
  output logic [mrg3_pkg::WordWidth-1:0] op_middle_o,
  output logic [mrg3_pkg::WordWidth-1:0] word_o
);

  logic [mrg3_pkg::WordWidth-1:0] op_oldest;
  logic [47:0] prod_newest, prod_middle, prod_oldest;
  logic [49:0] sum;
  logic [17:0] sum_hi;
  logic [32:0] fold1;
  logic [31:0] fold2;

  // restart replaces the whole history with the seed before the step
  assign op_newest_o = restart_i ? cfg_i.seed_value : hist_newest_i;
  assign op_middle_o = restart_i ? cfg_i.seed_value : hist_middle_i;
  assign op_oldest   = restart_i ? cfg_i.seed_value : hist_oldest_i;

  assign prod_newest = 48'(cfg_i.mult_newest) * 48'(op_newest_o);
  assign prod_middle = 48'(cfg_i.mult_middle) * 48'(op_middle_o);
  assign prod_oldest = 48'(cfg_i.mult_oldest) * 48'(op_oldest);

  assign sum    = 50'(prod_newest) + 50'(prod_middle) + 50'(prod_oldest);
  assign sum_hi = sum[49:32];

  // 2^32 == 5 mod m, so fold the high part down twice
  assign fold1 = 33'(sum[31:0]) + 33'(sum_hi) * 33'(mrg3_pkg::FoldFactor);
  // after a carry the low part is small, so this cannot overflow
  assign fold2 = fold1[31:0] + (fold1[32] ? 32'(mrg3_pkg::FoldFactor) : 32'd0);

  assign word_o = (fold2 >= mrg3_pkg::Modulus) ? (fold2 - mrg3_pkg::Modulus) : fold2;

endmodule

// File: tb/tb_third_order_recursive_random_generator.sv
// testbench for the third-order recursive random word generator
`timescale 1ns / 1ps

module tb_third_order_recursive_random_generator;
  import mrg3_pkg::*;

  localparam int unsigned IdxW = CfgIdxWidthDef;
  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned IdlePct = 32;

  // predicts the word stream and holds the words still owed by the block
  class mrg3_scoreboard;
    logic [WordWidth-1:0] seed, hist_n, hist_m, hist_o;
    logic [MultWidth-1:0] mul_n, mul_m, mul_o;
    logic [WordWidth-1:0] expected_words[$];
    int unsigned mismatches, checked, requests, reg_writes;

    function new();
      seed = SeedReset;
      mul_n = MultNewestReset;
      mul_m = MultMiddleReset;
      mul_o = MultOldestReset;
      hist_n = SeedReset;
      hist_m = SeedReset;
      hist_o = SeedReset;
      mismatches = 0;
      checked = 0;
      requests = 0;
      reg_writes = 0;
    endfunction

    function void set_reg(logic [IdxW-1:0] idx, logic [WordWidth-1:0] data);
      reg_writes++;
      case (idx)
        CFG_SEED:        seed = data;
        CFG_MULT_NEWEST: mul_n = data[MultWidth-1:0];
        CFG_MULT_MIDDLE: mul_m = data[MultWidth-1:0];
        CFG_MULT_OLDEST: mul_o = data[MultWidth-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic restart);
      logic [63:0] wsum;
      logic [WordWidth-1:0] word;
      requests++;
      if (restart) begin
        hist_n = seed;
        hist_m = seed;
        hist_o = seed;
      end
      // exact sum stays below 2^50
      wsum = 64'(mul_n) * 64'(hist_n) + 64'(mul_m) * 64'(hist_m)
           + 64'(mul_o) * 64'(hist_o);
      word = WordWidth'(wsum % 64'(Modulus));
      hist_o = hist_m;
      hist_m = hist_n;
      hist_n = word;
      expected_words.push_back(word);
    endfunction

    function void check_word(logic [WordWidth-1:0] actual);
      logic [WordWidth-1:0] want;
      if (expected_words.size() == 0) begin
        mismatches++;
        $display("%0t: random_word_o unexpected, expected none, actual %0d",
                 $time, actual);
      end else begin
        want = expected_words.pop_front();
        checked++;
        if (actual !== want) begin
          mismatches++;
          $display("%0t: random_word_o mismatch, expected %0d, actual %0d",
                   $time, want, actual);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic restart_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [IdxW-1:0] cfg_index_i = '0;
  logic [WordWidth-1:0] cfg_data_i = '0;
  logic in_ready_o, out_valid_o, cfg_ready_o;
  logic [WordWidth-1:0] random_word_o;

  mrg3_scoreboard sb = new();
  bit calm = 1'b0;
  int unsigned cycles = 0;
  int unsigned settings = 0;

  third_order_recursive_random_generator DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .random_word_o(random_word_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= IdlePct);
  end

  // all transfers are seen here on pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) sb.note_request(restart_i);
      if (out_valid_o && out_ready_i) sb.check_word(random_word_o);
    end
  end

  task automatic send_request(input logic restart);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      restart_i <= 1'($urandom_range(1));
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i <= restart;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [WordWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // only called with the block idle
  task automatic write_config(input logic [WordWidth-1:0] seed, input logic [WordWidth-1:0] mn,
                              input logic [WordWidth-1:0] mm, input logic [WordWidth-1:0] mo,
                              input bit stray);
    write_reg(CFG_SEED, seed);
    write_reg(CFG_MULT_NEWEST, mn);
    write_reg(CFG_MULT_MIDDLE, mm);
    write_reg(CFG_MULT_OLDEST, mo);
    // index past the last register must leave everything alone
    if (stray) write_reg(IdxW'($urandom_range(4, 255)), $urandom());
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    // let the monitor note the last request transfer first
    @(posedge clk_i);
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  function automatic logic [WordWidth-1:0] pick_mult();
    case ($urandom_range(5))
      0: return '0;
      1: return 32'h0000_FFFF;
      2: return 32'd1;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [WordWidth-1:0] seed;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset history and weights
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    wait_drained();

    // zero history, widest weights with junk above bit 15
    write_config('0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    wait_drained();

    // seed above the modulus, widest sum
    write_config(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 1'b1);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    wait_drained();

    write_config(Modulus, 32'h0000_FFFF, '0, 32'd1, 1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    wait_drained();

    write_config(Modulus - 1, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    wait_drained();

    // zero weights
    write_config($urandom(), '0, '0, '0, 1'b0);
    send_request(1'b1);
    send_request(1'b0);
    wait_drained();

    write_config(SeedReset, MultNewestReset, MultMiddleReset, MultOldestReset, 1'b0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(4))
        0: seed = '0;
        1: seed = Modulus - 1;
        2: seed = $urandom_range(32'hFFFF_FFFF, Modulus);
        default: seed = $urandom();
      endcase
      write_config(seed, pick_mult(), pick_mult(), pick_mult(), $urandom_range(99) < 30);
      calm = (p == 3);
      for (int k = 0; k < 100; k++) begin
        send_request(k == 0 ? ($urandom_range(1) == 1) : ($urandom_range(99) < 8));
      end
      wait_drained();
      calm = 1'b0;
    end

    repeat (4) @(posedge clk_i);
    $display("run covered %0d requests, %0d words checked, %0d register writes",
             sb.requests, sb.checked, sb.reg_writes);
    $display("over %0d register settings with stalls on both channels", settings);
    if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/mrg3_pkg.sv
hdl/mrg3_cfg.sv
hdl/mrg3_step.sv
hdl/third_order_recursive_random_generator.sv
tb/tb_third_order_recursive_random_generator.sv
